FILE: rtl/boxcar_decimator_iq_and_real_unit_assert.svh
// assertion macros for the boxcar decimator
`ifndef BOXCAR_DECIMATOR_IQ_AND_REAL_UNIT_ASSERT_SVH
`define BOXCAR_DECIMATOR_IQ_AND_REAL_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define BDR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, checked out of reset
`define BDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define BDR_ASSERT_NOW(label, ante, cons)
`define BDR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/bdr_pkg.sv
// shared constants and types of the boxcar decimator
`default_nettype none

package bdr_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int SUM_WIDTH      = 27;
    localparam int PHASE_WIDTH    = 21;
    localparam int DECIM_WIDTH    = 11;
    localparam int IRATE_WIDTH    = 20;
    localparam int ORATE_WIDTH    = 16;
    localparam int CFG_DATA_WIDTH = 20;
    localparam int CFG_ADDR_WIDTH = 2;
    localparam int CNT_WIDTH      = $clog2(SUM_WIDTH);

    localparam logic [DECIM_WIDTH-1:0] DECIM_RESET = DECIM_WIDTH'(4);
    localparam logic [IRATE_WIDTH-1:0] IRATE_RESET = IRATE_WIDTH'(230000);
    localparam logic [ORATE_WIDTH-1:0] ORATE_RESET = ORATE_WIDTH'(22050);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV1,
        ST_DIV2,
        ST_PUT
    } state_t;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_MODE,
        REG_DECIM,
        REG_IRATE,
        REG_ORATE
    } reg_index_t;

endpackage

`default_nettype wire

FILE: rtl/boxcar_decimator_iq_and_real_unit.sv
// boxcar integrate-and-dump decimator, complex and real modes
//
// input words arrive on s_valid/s_ready, results leave on m_valid/m_ready.
// mode 0 sums decim_factor i/q pairs and dumps both sums, low bits only.
// mode 1 sums real samples and steps a phase by output_rate; when the phase
// reaches input_rate the sum is divided by input_rate/output_rate and dumped.
// a word is taken in one cycle and worked on in the next; a word that makes
// no result sends the sequencer back to idle after accumulating, a mode 0
// dump after the put state. a mode 1 dump runs one shared restoring divider
// twice, 20 steps for the rate quotient, then 27 steps for the sum. s_ready
// is high only while the sequencer is idle. the result sits in an output
// register, so the next word is taken while a result waits; a stalled
// receiver holds a finished result in the sequencer until the output
// register frees up. reset clears sums, phase, output valid and loads the
// default registers. the user must write the configuration through
// cfg_wr_en/cfg_addr/cfg_wdata only while idle; the block never checks.
`default_nettype none

`include "boxcar_decimator_iq_and_real_unit_assert.svh"

module boxcar_decimator_iq_and_real_unit (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        cfg_wr_en,
    input  wire logic [bdr_pkg::CFG_ADDR_WIDTH-1:0]          cfg_addr,
    input  wire logic [bdr_pkg::CFG_DATA_WIDTH-1:0]          cfg_wdata,
    input  wire logic                                        s_valid,
    output logic                                             s_ready,
    input  wire logic signed [bdr_pkg::SAMPLE_WIDTH-1:0]     s_sample_i,
    input  wire logic signed [bdr_pkg::SAMPLE_WIDTH-1:0]     s_sample_q,
    input  wire logic                                        s_end_of_buffer,
    output logic                                             m_valid,
    input  wire logic                                        m_ready,
    output logic signed [bdr_pkg::SAMPLE_WIDTH-1:0]          m_out_i,
    output logic signed [bdr_pkg::SAMPLE_WIDTH-1:0]          m_out_q
);

    localparam int SW = bdr_pkg::SAMPLE_WIDTH;
    localparam int XW = bdr_pkg::SUM_WIDTH;
    localparam int PW = bdr_pkg::PHASE_WIDTH;
    localparam int DW = bdr_pkg::DECIM_WIDTH;
    localparam int IW = bdr_pkg::IRATE_WIDTH;
    localparam int OW = bdr_pkg::ORATE_WIDTH;
    localparam int CW = bdr_pkg::CNT_WIDTH;

    bdr_pkg::state_t state_reg, state_next;

    logic          mode_reg, mode_next;
    logic [DW-1:0] decim_reg, decim_next;
    logic [IW-1:0] irate_reg, irate_next;
    logic [OW-1:0] orate_reg, orate_next;

    logic [XW-1:0] sum_i_reg, sum_i_next;
    logic [XW-1:0] sum_q_reg, sum_q_next;
    logic [PW-1:0] phase_reg, phase_next;

    logic [SW-1:0] smp_i_reg, smp_i_next;
    logic [SW-1:0] smp_q_reg, smp_q_next;
    logic [XW-1:0] acc_reg, acc_next;
    logic [XW-1:0] dvd_reg, dvd_next;
    logic [IW-1:0] rem_reg, rem_next;
    logic [IW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] res_i_reg, res_i_next;
    logic [SW-1:0] res_q_reg, res_q_next;

    logic          m_valid_reg, m_valid_next;
    logic [SW-1:0] out_i_reg, out_i_next;
    logic [SW-1:0] out_q_reg, out_q_next;

    // extended samples and accumulator updates
    logic [XW-1:0] ext_i, ext_q, sum_i_add, sum_q_add;
    logic [PW-1:0] phase_inc, phase_add;
    logic [IW+1:0] trial;
    logic          ge;
    logic [IW-1:0] rem_step;
    logic [XW-1:0] dvd_step;
    logic [IW-1:0] rate_quot;
    logic [SW-1:0] mag_low;
    logic          put_fire;

    assign ext_i     = {{(XW-SW){smp_i_reg[SW-1]}}, smp_i_reg};
    assign ext_q     = {{(XW-SW){smp_q_reg[SW-1]}}, smp_q_reg};
    assign sum_i_add = sum_i_reg + ext_i;
    assign sum_q_add = sum_q_reg + ext_q;
    assign phase_inc = phase_reg + PW'(1);
    assign phase_add = phase_reg + {{(PW-OW){1'b0}}, orate_reg};

    // one restoring division step
    assign trial    = {1'b0, rem_reg, dvd_reg[XW-1]} - {2'b00, dsr_reg};
    assign ge       = ~trial[IW+1];
    assign rem_step = ge ? trial[IW-1:0] : {rem_reg[IW-2:0], dvd_reg[XW-1]};
    assign dvd_step = {dvd_reg[XW-2:0], ge};
    assign rate_quot = dvd_step[IW-1:0];
    assign mag_low   = dvd_step[SW-1:0];

    assign put_fire = (state_reg == bdr_pkg::ST_PUT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bdr_pkg::ST_IDLE;
            mode_reg    <= 1'b0;
            decim_reg   <= bdr_pkg::DECIM_RESET;
            irate_reg   <= bdr_pkg::IRATE_RESET;
            orate_reg   <= bdr_pkg::ORATE_RESET;
            sum_i_reg   <= '0;
            sum_q_reg   <= '0;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            decim_reg   <= decim_next;
            irate_reg   <= irate_next;
            orate_reg   <= orate_next;
            sum_i_reg   <= sum_i_next;
            sum_q_reg   <= sum_q_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        smp_i_reg <= smp_i_next;
        smp_q_reg <= smp_q_next;
        acc_reg   <= acc_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        cnt_reg   <= cnt_next;
        res_i_reg <= res_i_next;
        res_q_reg <= res_q_next;
        out_i_reg <= out_i_next;
        out_q_reg <= out_q_next;
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        decim_next   = decim_reg;
        irate_next   = irate_reg;
        orate_next   = orate_reg;
        sum_i_next   = sum_i_reg;
        sum_q_next   = sum_q_reg;
        phase_next   = phase_reg;
        smp_i_next   = smp_i_reg;
        smp_q_next   = smp_q_reg;
        acc_next     = acc_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        dsr_next     = dsr_reg;
        cnt_next     = cnt_reg;
        res_i_next   = res_i_reg;
        res_q_next   = res_q_reg;
        out_i_next   = out_i_reg;
        out_q_next   = out_q_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (bdr_pkg::reg_index_t'(cfg_addr))
                bdr_pkg::REG_MODE:  mode_next  = cfg_wdata[0];
                bdr_pkg::REG_DECIM: decim_next = cfg_wdata[DW-1:0];
                bdr_pkg::REG_IRATE: irate_next = cfg_wdata[IW-1:0];
                bdr_pkg::REG_ORATE: orate_next = cfg_wdata[OW-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            bdr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    smp_i_next = s_sample_i;
                    smp_q_next = s_sample_q;
                    state_next = bdr_pkg::ST_ACC;
                end
            end
            bdr_pkg::ST_ACC: begin
                if (!mode_reg) begin
                    if (phase_inc < {{(PW-DW){1'b0}}, decim_reg}) begin
                        sum_i_next = sum_i_add;
                        sum_q_next = sum_q_add;
                        phase_next = phase_inc;
                        state_next = bdr_pkg::ST_IDLE;
                    end else begin
                        res_i_next = sum_i_add[SW-1:0];
                        res_q_next = sum_q_add[SW-1:0];
                        sum_i_next = '0;
                        sum_q_next = '0;
                        phase_next = '0;
                        state_next = bdr_pkg::ST_PUT;
                    end
                end else begin
                    if (phase_add < {{(PW-IW){1'b0}}, irate_reg}) begin
                        sum_i_next = sum_i_add;
                        phase_next = phase_add;
                        state_next = bdr_pkg::ST_IDLE;
                    end else begin
                        acc_next   = sum_i_add;
                        sum_i_next = '0;
                        phase_next = phase_add - {{(PW-IW){1'b0}}, irate_reg};
                        dvd_next   = {irate_reg, {(XW-IW){1'b0}}};
                        rem_next   = '0;
                        dsr_next   = {{(IW-OW){1'b0}}, orate_reg};
                        cnt_next   = CW'(IW - 1);
                        state_next = bdr_pkg::ST_DIV1;
                    end
                end
            end
            bdr_pkg::ST_DIV1: begin
                dvd_next = dvd_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    // zero rate or zero quotient divides by one
                    if (orate_reg == '0 || rate_quot == '0) begin
                        dsr_next = IW'(1);
                    end else begin
                        dsr_next = rate_quot;
                    end
                    dvd_next   = acc_reg[XW-1] ? (~acc_reg + XW'(1)) : acc_reg;
                    rem_next   = '0;
                    cnt_next   = CW'(XW - 1);
                    state_next = bdr_pkg::ST_DIV2;
                end
            end
            bdr_pkg::ST_DIV2: begin
                dvd_next = dvd_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    res_i_next = acc_reg[XW-1] ? (~mag_low + SW'(1)) : mag_low;
                    res_q_next = '0;
                    state_next = bdr_pkg::ST_PUT;
                end
            end
            bdr_pkg::ST_PUT: begin
                if (put_fire) begin
                    out_i_next   = res_i_reg;
                    out_q_next   = res_q_reg;
                    m_valid_next = 1'b1;
                    state_next   = bdr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bdr_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_out_i = out_i_reg;
    assign m_out_q = out_q_reg;

    `BDR_ASSERT_NEXT(a_accept_to_acc, s_valid && s_ready, state_reg == bdr_pkg::ST_ACC)
    `BDR_ASSERT_NOW(a_div_nonzero, state_reg == bdr_pkg::ST_DIV2, dsr_reg != '0)
    `BDR_ASSERT_NOW(a_div_count, state_reg == bdr_pkg::ST_DIV1, cnt_reg < CW'(IW))
    `BDR_ASSERT_NEXT(a_put_loads, put_fire, m_valid && state_reg == bdr_pkg::ST_IDLE)

endmodule

`default_nettype wire
